// File: src/swr_pkg.sv
package swr_pkg;

   localparam int MAX_WORD_DEF = 16;
   localparam int REG_BYTES    = 16;
   localparam int LEN_W        = 5;
   localparam int IDX_W        = 4;
   localparam int CNT_W        = 16;
   localparam int CSR_AW       = 3;
   localparam int CSR_DW       = 64;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [CSR_AW-1:0] CSR_WORD_LO  = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_WORD_HI  = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_WORD_LEN = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_REPL_LO  = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_REPL_HI  = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_REPL_LEN = 3'd5;

   // effective lengths, already clamped
   typedef struct packed {
      logic [REG_BYTES-1:0][7:0] word_bytes;
      logic [LEN_W-1:0]          word_len;
      logic [REG_BYTES-1:0][7:0] repl_bytes;
      logic [LEN_W-1:0]          repl_len;
   } swr_cfg_type;

   // one burst of results, handed from front to back
   typedef struct packed {
      logic [LEN_W-1:0] byte_count;
      logic             use_repl;
      logic             text_end;
      logic [CNT_W-1:0] count;
   } swr_cmd_type;

   function automatic int win_size(input int max_word);
      return (max_word < REG_BYTES) ? max_word : REG_BYTES;
   endfunction

endpackage

// File: src/swr_csr.sv
module swr_csr import swr_pkg::*; #(
   parameter int MAX_WORD = MAX_WORD_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata,
   output swr_cfg_type       cfg
);

   localparam int WIN = win_size(MAX_WORD);
   localparam logic [LEN_W-1:0] WIN_LEN = LEN_W'(WIN);
   localparam logic [LEN_W-1:0] REG_LEN = LEN_W'(REG_BYTES);

   logic [CSR_DW-1:0] word_lo_ff, word_lo_in, word_hi_ff, word_hi_in;
   logic [CSR_DW-1:0] repl_lo_ff, repl_lo_in, repl_hi_ff, repl_hi_in;
   logic [LEN_W-1:0]  word_len_ff, word_len_in, repl_len_ff, repl_len_in;

   always_comb begin
      word_lo_in  = word_lo_ff;
      word_hi_in  = word_hi_ff;
      word_len_in = word_len_ff;
      repl_lo_in  = repl_lo_ff;
      repl_hi_in  = repl_hi_ff;
      repl_len_in = repl_len_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_WORD_LO:  word_lo_in  = csr_wdata;
            CSR_WORD_HI:  word_hi_in  = csr_wdata;
            CSR_WORD_LEN: word_len_in = csr_wdata[LEN_W-1:0];
            CSR_REPL_LO:  repl_lo_in  = csr_wdata;
            CSR_REPL_HI:  repl_hi_in  = csr_wdata;
            CSR_REPL_LEN: repl_len_in = csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_lo_ff  <= '0;
         word_hi_ff  <= '0;
         word_len_ff <= LEN_W'(1);
         repl_lo_ff  <= '0;
         repl_hi_ff  <= '0;
         repl_len_ff <= '0;
      end else begin
         word_lo_ff  <= word_lo_in;
         word_hi_ff  <= word_hi_in;
         word_len_ff <= word_len_in;
         repl_lo_ff  <= repl_lo_in;
         repl_hi_ff  <= repl_hi_in;
         repl_len_ff <= repl_len_in;
      end
   end

   always_comb begin
      cfg.word_bytes = {word_hi_ff, word_lo_ff};
      cfg.repl_bytes = {repl_hi_ff, repl_lo_ff};
      if (word_len_ff == '0) begin
         cfg.word_len = LEN_W'(1);
      end else if (word_len_ff > WIN_LEN) begin
         cfg.word_len = WIN_LEN;
      end else begin
         cfg.word_len = word_len_ff;
      end
      cfg.repl_len = (repl_len_ff > REG_LEN) ? REG_LEN : repl_len_ff;
   end

endmodule

// File: src/swr_front.sv
module swr_front import swr_pkg::*; #(
   parameter int MAX_WORD = MAX_WORD_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  swr_cfg_type                           cfg,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [7:0]                            req_text_byte,
   input  logic                                  req_text_end,
   input  logic                                  q_full,
   output logic                                  q_push,
   output swr_cmd_type                           q_cmd,
   output logic [win_size(MAX_WORD)-1:0][7:0]    q_snap
);

   localparam int WIN = win_size(MAX_WORD);

   logic [WIN-1:0][7:0] win_ff, win_in, win_app, win_sh;
   logic [WIN-1:0]      byte_ok;
   logic [LEN_W-1:0]    fill_ff, fill_in, fill_app, pop_n, emit_n;
   logic [CNT_W-1:0]    count_ff, count_in, count_next;
   logic                accept, over, equal, hit;

   assign req_stall = q_full;

   always_comb begin
      accept   = req_valid && !q_full;
      fill_app = fill_ff + LEN_W'(1);

      // the fill before the append is always below the window size
      for (int i = 0; i < WIN; i++) begin
         win_app[i] = (LEN_W'(i) == fill_ff) ? req_text_byte : win_ff[i];
         byte_ok[i] = (LEN_W'(i) >= cfg.word_len) || (win_app[i] == cfg.word_bytes[i]);
      end

      over  = fill_app > cfg.word_len;
      equal = fill_app == cfg.word_len;
      hit   = equal && (&byte_ok);

      if (over) begin
         pop_n = fill_app - cfg.word_len + LEN_W'(1);
      end else if (equal && !hit) begin
         pop_n = LEN_W'(1);
      end else begin
         pop_n = '0;
      end

      count_next = (hit && count_ff != '1) ? count_ff + CNT_W'(1) : count_ff;
      emit_n     = req_text_end ? (hit ? '0 : fill_app) : pop_n;

      // drop the popped bytes from the front of the window
      for (int i = 0; i < WIN; i++) begin
         win_sh[i] = win_app[i];
         for (int s = 1; s < WIN - i; s++) begin
            if (pop_n == LEN_W'(s)) begin
               win_sh[i] = win_app[i + s];
            end
         end
      end

      q_cmd.byte_count = emit_n;
      q_cmd.use_repl   = hit;
      q_cmd.text_end   = req_text_end;
      q_cmd.count      = count_next;
      q_snap           = win_app;
      q_push = accept && (req_text_end || emit_n != '0 || (hit && cfg.repl_len != '0));

      win_in   = win_ff;
      fill_in  = fill_ff;
      count_in = count_ff;
      if (accept) begin
         if (req_text_end) begin
            fill_in  = '0;
            count_in = '0;
         end else if (hit) begin
            fill_in  = '0;
            count_in = count_next;
         end else begin
            win_in   = win_sh;
            fill_in  = fill_app - pop_n;
            count_in = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         count_ff <= '0;
      end else begin
         fill_ff  <= fill_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

// File: src/swr_queue.sv
module swr_queue import swr_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             full,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [OCC_W-1:0] DEPTH_OCC = OCC_W'(QUEUE_DEPTH);

   logic [WIDTH-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [OCC_W-1:0] occ_ff, occ_in;

   assign full       = occ_ff == DEPTH_OCC;
   assign head_valid = occ_ff != '0;
   assign head_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      occ_in    = occ_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         occ_in = occ_ff + OCC_W'(1);
      end else if (pop && !push) begin
         occ_in = occ_ff - OCC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         occ_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         occ_ff    <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: src/swr_back.sv
module swr_back import swr_pkg::*; #(
   parameter int MAX_WORD = MAX_WORD_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  swr_cfg_type                           cfg,
   input  logic                                  head_valid,
   input  swr_cmd_type                           head_cmd,
   input  logic [win_size(MAX_WORD)-1:0][7:0]    head_snap,
   output logic                                  q_pop,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [7:0]                            rsp_out_byte,
   output logic                                  rsp_has_byte,
   output logic                                  rsp_run_last,
   output logic                                  rsp_text_done,
   output logic [CNT_W-1:0]                      rsp_replace_count
);

   localparam int WIN = win_size(MAX_WORD);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [LEN_W-1:0] total;
   logic [7:0]       snap_byte, cur_byte;
   logic             empty, last, load;

   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             has_ff, has_in, last_ff, last_in, done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      total = head_cmd.use_repl ? cfg.repl_len : head_cmd.byte_count;
      empty = total == '0;
      last  = empty || ({1'b0, idx_ff} == total - LEN_W'(1));

      snap_byte = '0;
      for (int i = 0; i < WIN; i++) begin
         if (idx_ff == IDX_W'(i)) begin
            snap_byte = head_snap[i];
         end
      end
      cur_byte = head_cmd.use_repl ? cfg.repl_bytes[idx_ff] : snap_byte;

      // the output register takes a new item whenever it is free or draining
      load  = head_valid && (!valid_ff || !rsp_stall);
      q_pop = load && last;

      idx_in   = idx_ff;
      valid_in = valid_ff && rsp_stall;
      byte_in  = byte_ff;
      has_in   = has_ff;
      last_in  = last_ff;
      done_in  = done_ff;
      count_in = count_ff;
      if (load) begin
         idx_in   = last ? '0 : idx_ff + IDX_W'(1);
         valid_in = 1'b1;
         byte_in  = empty ? 8'd0 : cur_byte;
         has_in   = !empty;
         last_in  = last;
         done_in  = last && head_cmd.text_end;
         count_in = head_cmd.count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      has_ff   <= has_in;
      last_ff  <= last_in;
      done_ff  <= done_in;
      count_ff <= count_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_out_byte      = byte_ff;
   assign rsp_has_byte      = has_ff;
   assign rsp_run_last      = last_ff;
   assign rsp_text_done     = done_ff;
   assign rsp_replace_count = count_ff;

endmodule

// File: src/stream_word_replace.sv
// path: a result is registered in the command queue and then in the output register
// throughput: one text byte per cycle unless stalled; a burst of k results
//   goes out one by one (an empty closing item as one); the input stalls while
//   the 2-entry command queue holds two bursts, the one being emitted included
// reset: synchronous, active high; clears the match window fill, the count,
//   the queue, the output valid flag and sets the registers to their defaults
module stream_word_replace import swr_pkg::*; #(
   parameter int MAX_WORD = MAX_WORD_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_text_byte,
   input  logic              req_text_end,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_has_byte,
   output logic              rsp_run_last,
   output logic              rsp_text_done,
   output logic [CNT_W-1:0]  rsp_replace_count
);

   localparam int WIN    = win_size(MAX_WORD);
   localparam int CMD_W  = $bits(swr_cmd_type);
   localparam int Q_W    = CMD_W + WIN * 8;

   swr_cfg_type         cfg;
   swr_cmd_type         push_cmd, head_cmd;
   logic [WIN-1:0][7:0] push_snap, head_snap;
   logic                q_push, q_pop, q_full, head_valid;
   logic [Q_W-1:0]      head_data;

   swr_csr #(.MAX_WORD(MAX_WORD)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   swr_front #(.MAX_WORD(MAX_WORD)) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_text_byte (req_text_byte),
      .req_text_end  (req_text_end),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_cmd         (push_cmd),
      .q_snap        (push_snap)
   );

   swr_queue #(.WIDTH(Q_W)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  ({push_cmd, push_snap}),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   assign head_cmd  = head_data[Q_W-1 -: CMD_W];
   assign head_snap = head_data[WIN*8-1:0];

   swr_back #(.MAX_WORD(MAX_WORD)) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .head_valid        (head_valid),
      .head_cmd          (head_cmd),
      .head_snap         (head_snap),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_has_byte      (rsp_has_byte),
      .rsp_run_last      (rsp_run_last),
      .rsp_text_done     (rsp_text_done),
      .rsp_replace_count (rsp_replace_count)
   );

   // an empty item only ever closes a text
   a_empty_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_byte |-> rsp_text_done && rsp_run_last)
      else $error("empty result that does not close the text");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_text_done |-> rsp_run_last)
      else $error("text end not on the last result of its byte");

   // a burst goes out without gaps and with one count
   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_run_last |=>
         rsp_valid && $stable(rsp_replace_count))
      else $error("burst interrupted or count changed within a burst");

endmodule

// File: sim/stream_word_replace_tb.sv
`timescale 1ns / 1ps

import swr_pkg::*;

typedef struct packed {
   logic [7:0]       out_byte;
   logic             has_byte;
   logic             run_last;
   logic             text_done;
   logic [CNT_W-1:0] count;
} text_result_type;

class rewrite_scoreboard;
   logic [CSR_DW-1:0] word_lo, word_hi, repl_lo, repl_hi;
   logic [LEN_W-1:0]  word_len, repl_len;
   logic [7:0]        window [REG_BYTES];
   int unsigned       fill, made, errors;
   text_result_type   pending [$];

   function new();
      word_lo = '0;
      word_hi = '0;
      repl_lo = '0;
      repl_hi = '0;
      word_len = LEN_W'(1);
      repl_len = '0;
      fill = 0;
      made = 0;
      errors = 0;
      foreach (window[i]) window[i] = '0;
   endfunction

   function void write_reg(logic [CSR_AW-1:0] idx, logic [CSR_DW-1:0] value);
      case (idx)
         CSR_WORD_LO:  word_lo = value;
         CSR_WORD_HI:  word_hi = value;
         CSR_WORD_LEN: word_len = value[LEN_W-1:0];
         CSR_REPL_LO:  repl_lo = value;
         CSR_REPL_HI:  repl_hi = value;
         CSR_REPL_LEN: repl_len = value[LEN_W-1:0];
         default: ;
      endcase
   endfunction

   function logic [7:0] pick(logic [CSR_DW-1:0] lo, logic [CSR_DW-1:0] hi, int unsigned idx);
      return (idx < 8) ? lo[idx*8 +: 8] : hi[(idx-8)*8 +: 8];
   endfunction

   function logic [7:0] shift_out();
      logic [7:0] b;
      b = window[0];
      for (int unsigned i = 1; i < fill; i++) window[i-1] = window[i];
      fill--;
      return b;
   endfunction

   function text_result_type byte_result(logic [7:0] b, logic has);
      return '{b, has, 1'b0, 1'b0, made[CNT_W-1:0]};
   endfunction

   // works out every result caused by one accepted text byte
   function void note_text(logic [7:0] b, logic last_byte);
      text_result_type burst [$];
      int unsigned     wlen, rlen, i;
      bit              hit;
      wlen = (word_len == 0) ? 1 : ((word_len > REG_BYTES) ? REG_BYTES : word_len);
      rlen = (repl_len > REG_BYTES) ? REG_BYTES : repl_len;
      if (fill < REG_BYTES) begin
         window[fill] = b;
         fill++;
      end
      if (fill > wlen) begin
         // word shortened mid-text: drain to one short of the word, no match test
         while (fill > wlen - 1) burst.push_back(byte_result(shift_out(), 1'b1));
      end else if (fill == wlen) begin
         hit = 1'b1;
         for (i = 0; i < wlen; i++)
            if (window[i] != pick(word_lo, word_hi, i)) hit = 1'b0;
         if (hit) begin
            if (made < 16'hFFFF) made++;
            fill = 0;
            for (i = 0; i < rlen; i++)
               burst.push_back(byte_result(pick(repl_lo, repl_hi, i), 1'b1));
         end else begin
            burst.push_back(byte_result(shift_out(), 1'b1));
         end
      end
      if (last_byte) begin
         while (fill > 0) burst.push_back(byte_result(shift_out(), 1'b1));
         if (burst.size() == 0) burst.push_back(byte_result(8'h00, 1'b0));
         burst[burst.size()-1].text_done = 1'b1;
      end
      if (burst.size() > 0) burst[burst.size()-1].run_last = 1'b1;
      if (last_byte) begin
         made = 0;
         fill = 0;
      end
      foreach (burst[k]) pending.push_back(burst[k]);
   endfunction

   function void compare(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
         errors++;
      end
   endfunction

   function void check_result(text_result_type got);
      text_result_type want;
      if (pending.size() == 0) begin
         $display("%0t: transfer with nothing expected, expected none actual byte %0h count %0d",
                  $time, got.out_byte, got.count);
         errors++;
         return;
      end
      want = pending.pop_front();
      compare("out_byte", want.out_byte, got.out_byte);
      compare("has_byte", want.has_byte, got.has_byte);
      compare("run_last", want.run_last, got.run_last);
      compare("text_done", want.text_done, got.text_done);
      compare("replace_count", want.count, got.count);
   endfunction
endclass

module stream_word_replace_tb;
   localparam int QUIET_LIMIT  = 4000;
   localparam int LONG_HOLD    = 300;
   localparam int RANDOM_ITEMS = 350;
   localparam int PRESS_ITEMS  = 40;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_we = 1'b0;
   logic [CSR_AW-1:0] csr_index = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [7:0]        req_text_byte = '0;
   logic              req_text_end = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [7:0]        rsp_out_byte;
   logic              rsp_has_byte;
   logic              rsp_run_last;
   logic              rsp_text_done;
   logic [CNT_W-1:0]  rsp_replace_count;

   rewrite_scoreboard sb = new();
   logic [7:0]        text_q [$];
   int                req_gap_max = 16;
   int                rsp_gap_max = 16;
   int unsigned       quiet = 0;
   logic              pressure = 1'b0;

   stream_word_replace dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // result side: random stall per transfer, now and then a long hold
   initial begin : rsp_side
      int unsigned     hold, taken;
      bit              pressed;
      text_result_type got;
      hold = 0;
      taken = 0;
      pressed = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_out_byte, rsp_has_byte, rsp_run_last, rsp_text_done,
                    rsp_replace_count};
            sb.check_result(got);
            taken++;
            // long hold so the queue fills and the front stalls
            hold = (taken % 150 == 0) ? LONG_HOLD : $urandom_range(rsp_gap_max, 0);
         end
         // one long hold while a long text keeps coming
         if (pressure && !pressed) begin
            pressed = 1'b1;
            hold = LONG_HOLD;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic configure(input logic [CSR_DW-1:0] wlo, input logic [CSR_DW-1:0] whi,
                            input int unsigned wlen, input logic [CSR_DW-1:0] rlo,
                            input logic [CSR_DW-1:0] rhi, input int unsigned rlen);
      logic [CSR_DW-1:0] vals [6];
      logic [CSR_AW-1:0] idx [6];
      vals = '{wlo, whi, CSR_DW'(wlen), rlo, rhi, CSR_DW'(rlen)};
      idx = '{CSR_WORD_LO, CSR_WORD_HI, CSR_WORD_LEN, CSR_REPL_LO, CSR_REPL_HI,
              CSR_REPL_LEN};
      for (int i = 0; i < 6; i++) begin
         csr_we <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         sb.write_reg(idx[i], vals[i]);
      end
      csr_we <= 1'b0;
   endtask

   task automatic send_item(input logic [7:0] b, input logic last_byte);
      int unsigned gap;
      gap = $urandom_range(req_gap_max, 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_text_byte <= b;
      req_text_end <= last_byte;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_text(b, last_byte);
   endtask

   task automatic send_text(input bit ends);
      foreach (text_q[i]) send_item(text_q[i], ends && (i == text_q.size() - 1));
   endtask

   // block idle: every result in, then room for a byte still in flight
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [7:0]          alpha [4];
      logic [2*CSR_DW-1:0] word_bits;
      logic [CSR_DW-1:0]   rlo, rhi;
      int unsigned         wlen, elen, rlen, n, plen, texts, items;
      bit                  ends;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default registers: single zero byte, deleted
      text_q = {8'h00, 8'hFF, 8'h00};
      send_text(1'b1);
      settle();

      configure(64'h636261, 64'h0, 3, 64'h5A59_5857, 64'h0, 4);
      text_q = {8'h61, 8'h62, 8'h63, 8'h64};
      send_text(1'b1);
      settle();

      // zero word length acts as one, oversized replacement clamps
      configure(64'h71, 64'h0, 0, {CSR_DW{1'b1}}, 64'h0, 20);
      text_q = {8'h71, 8'h72};
      send_text(1'b1);
      settle();

      // oversized word length clamps to a full window, deletion, text left open
      configure(64'hFEDC_BA98_7654_3210, 64'h0123_4567_89AB_CDEF, 31, 64'h0, 64'h0, 0);
      text_q.delete();
      for (int i = 0; i < 8; i++) text_q.push_back(sb.word_lo[i*8 +: 8]);
      for (int i = 0; i < 8; i++) text_q.push_back(sb.word_hi[i*8 +: 8]);
      text_q.push_back(8'h78);
      text_q.push_back(8'h78);
      send_text(1'b0);
      settle();

      // shorter word while bytes are held
      configure(64'h7A79, 64'h0, 2, 64'h21, 64'h0, 1);
      text_q = {8'h79, 8'h7A};
      send_text(1'b1);
      settle();

      // receiver holds off while a long text is offered back to back
      req_gap_max = 0;
      rsp_gap_max = 0;
      configure(64'hFF, 64'h0, 1, 64'h0, 64'h0, 0);
      text_q.delete();
      for (int i = 0; i < PRESS_ITEMS; i++) text_q.push_back(8'(8'h30 + i));
      pressure <= 1'b1;
      send_text(1'b1);
      settle();
      pressure <= 1'b0;

      items = 0;
      while (items < RANDOM_ITEMS) begin
         foreach (alpha[i]) alpha[i] = 8'($urandom);
         for (int i = 0; i < REG_BYTES; i++) word_bits[i*8 +: 8] = alpha[$urandom_range(3, 0)];
         case ($urandom_range(9, 0))
            0: wlen = 0;
            1: wlen = $urandom_range(31, 17);
            2, 3: wlen = $urandom_range(16, 7);
            default: wlen = $urandom_range(6, 1);
         endcase
         elen = (wlen == 0) ? 1 : ((wlen > REG_BYTES) ? REG_BYTES : wlen);
         rlo = {$urandom, $urandom};
         rhi = {$urandom, $urandom};
         rlen = ($urandom_range(9, 0) == 0) ? $urandom_range(31, 17) : $urandom_range(16, 0);
         req_gap_max = $urandom_range(1, 0) ? 16 : 0;
         rsp_gap_max = $urandom_range(1, 0) ? 16 : 0;
         configure(word_bits[CSR_DW-1:0], word_bits[2*CSR_DW-1:CSR_DW], wlen, rlo, rhi, rlen);
         texts = $urandom_range(3, 1);
         for (int t = 0; t < texts; t++) begin
            text_q.delete();
            n = $urandom_range(24, 1);
            while (text_q.size() < n) begin
               case ($urandom_range(3, 0))
                  0, 1: begin
                     // whole word or a prefix of it
                     plen = $urandom_range(1, 0) ? elen : $urandom_range(elen, 1);
                     for (int i = 0; i < plen; i++) text_q.push_back(word_bits[i*8 +: 8]);
                  end
                  2: text_q.push_back(alpha[$urandom_range(3, 0)]);
                  default: text_q.push_back(8'($urandom));
               endcase
            end
            ends = (t < texts - 1) || ($urandom_range(3, 0) != 0);
            send_text(ends);
            items += text_q.size();
         end
         settle();
      end

      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

// File: stream_word_replace.f
src/swr_pkg.sv
src/swr_csr.sv
src/swr_front.sv
src/swr_queue.sv
src/swr_back.sv
src/stream_word_replace.sv
sim/stream_word_replace_tb.sv
